// ===== rtl/etwh_pkg.sv =====
package etwh_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int WORD_W        = 64;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_W         = 2 * KEY_WORDS * WORD_W;
    localparam int MODE_W        = 2;
    localparam int IDX_W         = 4;
    localparam int OUT_W         = 8;

    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic  wr_en;
        t_slot wr_addr;
        t_slot rd_addr;
    } t_store_ctl;

endpackage

// ===== rtl/exclusion_table_weight_hash_top.sv =====
// channel | dir | tdata                                     | tuser
// s       | in  | 512b: weight_w0..w3, hash_w0..w3 (low up) | mode (2b)
// m       | out | 8b: found, stored, slot_index[3:0], evict | -
//
// One request scans every slot: one slot row is read from the key store and
// compared per cycle, then the finish state decides and writes. A clear goes
// straight from idle to the finish state. o_s_tready is high only while idle.
// The result sits in an output register; a stalled m side holds the sequencer
// in its final state. Reset (i_rst_n low, synchronous) drops all valid marks.
module exclusion_table_weight_hash_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // [511:0] weight_w0, weight_w1, weight_w2, weight_w3, hash_w0..hash_w3
    input  logic [etwh_pkg::KEY_W-1:0]   i_s_tdata,
    // [1:0] mode
    input  logic [etwh_pkg::MODE_W-1:0]  i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [0] found, [1] stored, [5:2] slot_index, [6] evicted, [7] zero
    output logic [etwh_pkg::OUT_W-1:0]   o_m_tdata
);
    import etwh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} t_state;

    localparam t_slot LAST_SLOT = t_slot'(TABLE_ENTRIES - 1);

    t_state                   r_state, n_state;
    t_slot                    r_addr, n_addr;
    logic                     r_free_hit, n_free_hit;
    t_slot                    r_free_idx, n_free_idx;
    logic                     r_hit, n_hit;
    t_slot                    r_hit_idx, n_hit_idx;
    logic                     r_cmp_vld, n_cmp_vld;
    t_slot                    r_cmp_idx, n_cmp_idx;
    logic [MODE_W-1:0]        r_mode, n_mode;
    t_key                     r_key, n_key;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic                     r_out_valid, n_out_valid;
    logic [OUT_W-1:0]         r_out_data, n_out_data;

    t_store_ctl               w_ctl;
    logic                     w_match;
    t_slot                    w_slot;
    logic                     w_stored;
    t_slot                    w_rep_slot;
    logic [SLOT_W+IDX_W-1:0]  w_rep_ext;

    etwh_key_store u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_key   (r_key),
        .o_match (w_match)
    );

    assign w_slot     = r_free_hit ? r_free_idx : '0;
    assign w_stored   = (r_mode == MODE_ADD) && !r_hit;
    assign w_rep_slot = r_hit ? r_hit_idx : (w_stored ? w_slot : '0);
    assign w_rep_ext  = {{IDX_W{1'b0}}, w_rep_slot};

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_free_hit  = r_free_hit;
        n_free_idx  = r_free_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_mode      = r_mode;
        n_key       = r_key;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_cmp_vld   = (r_state == S_SCAN);
        n_cmp_idx   = r_addr;

        w_ctl.wr_en   = 1'b0;
        w_ctl.wr_addr = w_slot;
        w_ctl.rd_addr = r_addr;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        // compare stage, in the cycle after the row read
        if (r_cmp_vld && r_valid[r_cmp_idx] && w_match && !r_hit) begin
            n_hit     = 1'b1;
            n_hit_idx = r_cmp_idx;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_mode     = i_s_tuser;
                    n_key      = i_s_tdata;
                    n_addr     = '0;
                    n_hit      = 1'b0;
                    n_free_hit = 1'b0;
                    n_state    = (i_s_tuser == MODE_CLEAR) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                // remember the lowest free slot
                if (!r_valid[r_addr] && !r_free_hit) begin
                    n_free_hit = 1'b1;
                    n_free_idx = r_addr;
                end
                if (r_addr == LAST_SLOT) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + t_slot'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, w_stored && !r_free_hit, w_rep_ext[IDX_W-1:0],
                                   w_stored, r_hit};
                    if (r_mode == MODE_CLEAR) begin
                        n_valid = '0;
                    end else if (w_stored) begin
                        n_valid[w_slot] = 1'b1;
                        w_ctl.wr_en     = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_free_hit  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_cmp_vld   <= n_cmp_vld;
            r_hit       <= n_hit;
            r_free_hit  <= n_free_hit;
        end
        r_addr     <= n_addr;
        r_free_idx <= n_free_idx;
        r_hit_idx  <= n_hit_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_out_data <= n_out_data;
    end

    // hold ready low while reset is asserted
    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== rtl/etwh_key_store.sv =====
module etwh_key_store (
    input  logic                i_clk,
    input  etwh_pkg::t_store_ctl i_ctl,
    input  etwh_pkg::t_key      i_key,
    output logic                o_match
);
    import etwh_pkg::*;

    t_key r_mem [TABLE_ENTRIES];
    t_key r_rd_data;

    // one row per slot, read one row a cycle, write the request key
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_key;
        end
        r_rd_data <= r_mem[i_ctl.rd_addr];
    end

    // shared full-key comparator
    assign o_match = (r_rd_data == i_key);

endmodule
